@@ rtl/core/chained_integer_hash_map_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the chained integer hash map.
// Each macro checks one implication on the rising edge of clk while rst_n is high.
// ----------------------------------------------------------------------------
`ifndef CHAINED_INTEGER_HASH_MAP_MACROS_SVH
`define CHAINED_INTEGER_HASH_MAP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define CHM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CHM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/chm_pkg.sv @@
// ----------------------------------------------------------------------------
// Chained integer hash map package
// Shared constants, node layout, hash interface types and the bucket function.
// ----------------------------------------------------------------------------
`default_nettype none

package chm_pkg;

    localparam int KEY_W            = 31;
    localparam int BITS_W           = 4;
    localparam int MAX_BUCKET_BITS  = 10;
    localparam int BUCKET_W         = MAX_BUCKET_BITS;
    localparam int BUCKET_SLOTS     = 1 << MAX_BUCKET_BITS;
    localparam int NODE_COUNT       = 512;
    localparam int NODE_IDX_W       = $clog2(NODE_COUNT);
    localparam int CNT_W            = $clog2(NODE_COUNT + 1);
    localparam int HALF_W           = 16;
    localparam int PROD_W           = 32;

    localparam logic [PROD_W-1:0] HASH_MULT   = 32'd1103515249;
    localparam logic [BITS_W-1:0] BITS_RESET  = 4'd4;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [BUCKET_W-1:0]   bucket;
        logic [KEY_W-1:0]      key;
        logic [KEY_W-1:0]      data;
        logic [NODE_IDX_W-1:0] link;
        logic                  link_ok;
    } node_t;

    typedef struct packed {
        logic              start;
        logic [KEY_W-1:0]  key;
        logic [BITS_W-1:0] bits;
    } hash_req_t;

    typedef struct packed {
        logic                done;
        logic [BUCKET_W-1:0] bucket;
    } hash_rsp_t;

    // Takes the bucket bits below bit 30 of the 32-bit product, width clamped first.
    function automatic logic [BUCKET_W-1:0] bucket_of(
        input logic [PROD_W-1:0] prod,
        input logic [BITS_W-1:0] bits
    );
        logic [BITS_W-1:0]   ub;
        logic [4:0]          sh;
        logic [PROD_W-1:0]   shifted;
        logic [BUCKET_W-1:0] mask;
        ub = bits;
        if (ub == '0)
        begin
            ub = BITS_W'(1);
        end
        if (ub > BITS_W'(MAX_BUCKET_BITS))
        begin
            ub = BITS_W'(MAX_BUCKET_BITS);
        end
        sh      = 5'd30 - {1'b0, ub};
        shifted = prod >> sh;
        mask    = ~({BUCKET_W{1'b1}} << ub);
        return shifted[BUCKET_W-1:0] & mask;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/chm_hash_unit.sv @@
// ----------------------------------------------------------------------------
// Multiplicative hash unit
// Forms key times the hash constant with one shared 16 by 32 multiplier over
// two passes, then extracts the bucket index.
// ----------------------------------------------------------------------------
`default_nettype none

module chm_hash_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire chm_pkg::hash_req_t req,
    output chm_pkg::hash_rsp_t      rsp
);

    typedef enum logic [1:0] {H_IDLE, H_LO, H_HI, H_FIN} hstate_t;

    hstate_t                          state_reg;
    logic [chm_pkg::KEY_W-1:0]        key_reg;
    logic [chm_pkg::BITS_W-1:0]       bits_reg;
    logic [chm_pkg::PROD_W-1:0]       acc_reg;
    logic [chm_pkg::PROD_W-1:0]       acc_next;
    logic [chm_pkg::BUCKET_W-1:0]     bucket_reg;
    logic                             done_reg;
    logic [chm_pkg::HALF_W-1:0]       mul_a;
    logic [chm_pkg::PROD_W-1:0]       mul_p;
    logic [chm_pkg::PROD_W-1:0]       addend;

    // The high half of the key only reaches the upper 16 product bits.
    always_comb
    begin
        if (state_reg == H_HI)
        begin
            mul_a = {1'b0, key_reg[chm_pkg::KEY_W-1:chm_pkg::HALF_W]};
        end
        else
        begin
            mul_a = key_reg[chm_pkg::HALF_W-1:0];
        end
        mul_p = chm_pkg::PROD_W'({16'b0, mul_a} * chm_pkg::HASH_MULT);
        if (state_reg == H_HI)
        begin
            addend   = {mul_p[chm_pkg::HALF_W-1:0], 16'b0};
            acc_next = acc_reg + addend;
        end
        else
        begin
            addend   = mul_p;
            acc_next = addend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                H_IDLE:
                begin
                    if (req.start)
                    begin
                        key_reg   <= req.key;
                        bits_reg  <= req.bits;
                        state_reg <= H_LO;
                    end
                end
                H_LO:
                begin
                    acc_reg   <= acc_next;
                    state_reg <= H_HI;
                end
                H_HI:
                begin
                    acc_reg   <= acc_next;
                    state_reg <= H_FIN;
                end
                H_FIN:
                begin
                    bucket_reg <= chm_pkg::bucket_of(acc_reg, bits_reg);
                    done_reg   <= 1'b1;
                    state_reg  <= H_IDLE;
                end
                default:
                begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.bucket = bucket_reg;

endmodule

`default_nettype wire

@@ rtl/core/chained_integer_hash_map.sv @@
// ----------------------------------------------------------------------------
// Chained integer hash map
// Key to value map with separate chaining, a bucket head memory, a node pool
// memory and a sequencer that walks one chain node per cycle.
// ----------------------------------------------------------------------------
// Sequence: a lookup or insert passes the hash unit, the head read and head check,
// the node state per chain node visited and, for a new key, the insert state; a clear
// or unused code goes straight to the response. A new request is taken only once the
// last one has left the response state; a result not yet taken holds the sequencer in
// that state, which also delays the next request.
// Reset: clears control state and empties the table by zeroing the entry
// count; bucket heads are qualified against the pool, so no clearing pass runs.
`default_nettype none

module chained_integer_hash_map (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [chm_pkg::BITS_W-1:0]  cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  operation,
    input  wire logic [chm_pkg::KEY_W-1:0]   key,
    input  wire logic [chm_pkg::KEY_W-1:0]   value,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             found,
    output logic [chm_pkg::KEY_W-1:0]        stored_value,
    output logic                             status
);

    `include "chained_integer_hash_map_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_HASH, S_HEAD_RD, S_HEAD_CHK, S_NODE, S_INSERT, S_RESP
    } state_t;

    state_t                              state_reg;
    logic [chm_pkg::BITS_W-1:0]          bucket_bits_reg;
    logic [chm_pkg::CNT_W-1:0]           entry_count_reg;
    logic [1:0]                          op_reg;
    logic [chm_pkg::KEY_W-1:0]           key_reg;
    logic [chm_pkg::KEY_W-1:0]           value_reg;
    logic [chm_pkg::BUCKET_W-1:0]        bucket_reg;
    logic [chm_pkg::NODE_IDX_W-1:0]      head_ptr_reg;
    logic                                head_ok_reg;
    logic                                first_reg;
    logic                                res_found_reg;
    logic [chm_pkg::KEY_W-1:0]           res_value_reg;
    logic                                res_status_reg;
    logic                                out_valid_reg;
    logic                                found_reg;
    logic [chm_pkg::KEY_W-1:0]           stored_value_reg;
    logic                                status_reg;

    logic [chm_pkg::NODE_IDX_W-1:0]      bucket_mem [chm_pkg::BUCKET_SLOTS];
    logic [chm_pkg::NODE_IDX_W-1:0]      head_rdata_reg;
    chm_pkg::node_t                      node_mem [chm_pkg::NODE_COUNT];
    chm_pkg::node_t                      node_q_reg;
    logic [chm_pkg::NODE_IDX_W-1:0]      node_rd_addr;
    logic                                insert_we;
    chm_pkg::node_t                      node_wdata;
    logic [chm_pkg::NODE_IDX_W-1:0]      node_waddr;

    chm_pkg::hash_req_t                  hash_req;
    chm_pkg::hash_rsp_t                  hash_rsp;

    logic                                in_xfer;
    logic                                cfg_xfer;
    logic                                pool_full;
    logic                                head_in_pool;
    logic                                load_out;

    chm_hash_unit u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hash_req),
        .rsp   (hash_rsp)
    );

    // A pending configuration write goes ahead of a request offered in the same cycle.
    assign in_ready     = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready    = (state_reg == S_IDLE);
    assign in_xfer      = in_valid && in_ready;
    assign cfg_xfer     = cfg_valid && cfg_ready;
    assign pool_full    = (entry_count_reg == chm_pkg::CNT_W'(chm_pkg::NODE_COUNT));
    assign head_in_pool = (chm_pkg::CNT_W'(head_rdata_reg) < entry_count_reg);
    assign load_out     = (state_reg == S_RESP) && (!out_valid_reg || out_ready);
    assign insert_we    = (state_reg == S_INSERT) && !pool_full;
    assign node_waddr   = entry_count_reg[chm_pkg::NODE_IDX_W-1:0];

    assign hash_req.start = in_xfer && ((operation == chm_pkg::OP_LOOKUP) ||
                                        (operation == chm_pkg::OP_INSERT));
    assign hash_req.key   = key;
    assign hash_req.bits  = bucket_bits_reg;

    always_comb
    begin
        node_wdata.bucket  = bucket_reg;
        node_wdata.key     = key_reg;
        node_wdata.data    = value_reg;
        node_wdata.link    = head_ptr_reg;
        node_wdata.link_ok = head_ok_reg;
        if (state_reg == S_HEAD_CHK)
        begin
            node_rd_addr = head_rdata_reg;
        end
        else
        begin
            node_rd_addr = node_q_reg.link;
        end
    end

    always_ff @(posedge clk)
    begin
        head_rdata_reg <= bucket_mem[bucket_reg];
        if (insert_we)
        begin
            bucket_mem[bucket_reg] <= node_waddr;
        end
    end

    always_ff @(posedge clk)
    begin
        node_q_reg <= node_mem[node_rd_addr];
        if (insert_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            bucket_bits_reg <= chm_pkg::BITS_RESET;
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
            first_reg       <= 1'b0;
            head_ok_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_xfer)
            begin
                bucket_bits_reg <= cfg_data;
                entry_count_reg <= '0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        op_reg         <= operation;
                        key_reg        <= key;
                        value_reg      <= value;
                        res_found_reg  <= 1'b0;
                        res_value_reg  <= '0;
                        res_status_reg <= 1'b0;
                        if (hash_req.start)
                        begin
                            state_reg <= S_HASH;
                        end
                        else
                        begin
                            if (operation == chm_pkg::OP_CLEAR)
                            begin
                                entry_count_reg <= '0;
                            end
                            state_reg <= S_RESP;
                        end
                    end
                end
                S_HASH:
                begin
                    if (hash_rsp.done)
                    begin
                        bucket_reg <= hash_rsp.bucket;
                        state_reg  <= S_HEAD_RD;
                    end
                end
                S_HEAD_RD:
                begin
                    state_reg <= S_HEAD_CHK;
                end
                S_HEAD_CHK:
                begin
                    head_ptr_reg <= head_rdata_reg;
                    first_reg    <= 1'b1;
                    if (head_in_pool)
                    begin
                        state_reg <= S_NODE;
                    end
                    else
                    begin
                        head_ok_reg <= 1'b0;
                        state_reg   <= (op_reg == chm_pkg::OP_INSERT) ? S_INSERT : S_RESP;
                    end
                end
                S_NODE:
                begin
                    first_reg <= 1'b0;
                    // A head left over from before the last clear points at a node
                    // of another bucket.
                    if (first_reg && (node_q_reg.bucket != bucket_reg))
                    begin
                        head_ok_reg <= 1'b0;
                        state_reg   <= (op_reg == chm_pkg::OP_INSERT) ? S_INSERT : S_RESP;
                    end
                    else
                    begin
                        if (first_reg)
                        begin
                            head_ok_reg <= 1'b1;
                        end
                        if (node_q_reg.key == key_reg)
                        begin
                            res_found_reg <= 1'b1;
                            res_value_reg <= node_q_reg.data;
                            state_reg     <= S_RESP;
                        end
                        else if (!node_q_reg.link_ok)
                        begin
                            state_reg <= (op_reg == chm_pkg::OP_INSERT) ? S_INSERT : S_RESP;
                        end
                    end
                end
                S_INSERT:
                begin
                    if (pool_full)
                    begin
                        res_status_reg <= 1'b1;
                    end
                    else
                    begin
                        entry_count_reg <= entry_count_reg + chm_pkg::CNT_W'(1);
                    end
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (load_out)
                    begin
                        found_reg        <= res_found_reg;
                        stored_value_reg <= res_value_reg;
                        status_reg       <= res_status_reg;
                        out_valid_reg    <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign stored_value = stored_value_reg;
    assign status       = status_reg;

    `CHM_ASSERT_NEXT(a_busy_after_accept, in_xfer, !in_ready, "input taken while busy")
    `CHM_ASSERT_SAME(a_count_bound,
        1'b1, entry_count_reg <= chm_pkg::CNT_W'(chm_pkg::NODE_COUNT), "entry count overflow")
    `CHM_ASSERT_NEXT(a_cfg_empties, cfg_xfer, entry_count_reg == '0, "config did not empty table")
    `CHM_ASSERT_SAME(a_full_not_found, out_valid && status, !found, "full flag with a hit")

endmodule

`default_nettype wire
